// ===== sv/lph_pkg.sv =====
// Shared constants for the linear probing hash table.
// No dependencies; imported by lph_mod and the top level, not by lph_ram.
package lph_pkg;

  localparam int KEY_W        = 31;
  localparam int CFG_W        = 11;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int VALUE_W      = 10;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;

  localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] K_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] K_ERASE  = 2'd2;
  localparam logic [KIND_W-1:0] K_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] R_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] R_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] R_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] R_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] R_ERASED   = 3'd4;
  localparam logic [STATUS_W-1:0] R_FULL     = 3'd5;

endpackage

// ===== sv/lph_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lph_mod.sv =====
// Bit-serial remainder unit: key modulo active size, one key bit per cycle.
// Depends on lph_pkg.
module lph_mod #(
  parameter int IW = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [lph_pkg::KEY_W-1:0] dividend,
  input  logic [IW:0]             divisor,
  output logic                    done,
  output logic [IW-1:0]           rem
);
  import lph_pkg::*;

  localparam int RW    = IW + 2;
  localparam int CNT_W = $clog2(KEY_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] dvd_r, dvd_nxt;
  logic [IW:0]      dsr_r, dsr_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r[RW-2:0], dvd_r[KEY_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dsr_r}) ? trial - {1'b0, dsr_r} : trial;
      dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[IW-1:0];

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Linear probing hash table with backward-shift erase, top level.
// Depends on lph_pkg, lph_ram and lph_mod.
//
// Open-addressed table of 31-bit keys held in one RAM word per slot
// ({occupied, key}). Each request inserts, finds or erases a key and yields
// one response (kind 3 is taken and dropped). After reset a clearing pass
// writes every slot empty, with in_ready low; cfg writes are taken at any
// time. A request first hashes its key in the bit-serial remainder unit
// to find the home slot, then reads and checks one slot per probe step.
// An erase then, for every occupied slot walked after the removed one,
// reads it from RAM and hashes it; the walk ends at an empty slot, and
// the final gap is freed. The output register is loaded last; the next
// request can be taken while a response still waits on out_ready.
module linear_probe_hash_table #(
  parameter int CAPACITY = lph_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lph_pkg::KIND_W-1:0]   in_kind,
  input  logic [lph_pkg::KEY_W-1:0]    in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lph_pkg::STATUS_W-1:0] out_status,
  output logic [lph_pkg::VALUE_W-1:0]  out_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lph_pkg::CFG_W-1:0]    cfg_data
);
  import lph_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int NW = IW + 1;
  localparam int WW = KEY_W + 1;

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_HASH  = 10'b0000000100,
    S_PRD   = 10'b0000001000,
    S_PCHK  = 10'b0000010000,
    S_EREAD = 10'b0000100000,
    S_ECHK  = 10'b0001000000,
    S_EHASH = 10'b0010000000,
    S_EFIN  = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_t;

  state_t              st_r, st_nxt;
  logic [CFG_W-1:0]    size_r, size_nxt;
  logic [IW-1:0]       clr_r, clr_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    ekey_r, ekey_nxt;
  logic [IW-1:0]       home_r, home_nxt;
  logic [IW-1:0]       j_r, j_nxt;       // probe slot, later erase cursor
  logic [IW-1:0]       gap_r, gap_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]  moved_r, moved_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [VALUE_W-1:0]  res_val_r, res_val_nxt;
  logic                ov_r, ov_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;
  logic [VALUE_W-1:0]  oval_r, oval_nxt;

  logic [NW-1:0] n_w;
  logic [NW-1:0] j_p1, cnt_p1;
  logic [NW:0]   cnt_p2;
  logic [IW-1:0] j_next;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  logic             mod_start, mod_done;
  logic [KEY_W-1:0] mod_dvd;
  logic [IW-1:0]    mod_rem;

  logic r_occ, r_match, move;

  // Active size: zero acts as one, anything above CAPACITY is clamped.
  always_comb begin
    if (size_r == '0) begin
      n_w = NW'(1);
    end else if (32'(size_r) > 32'(CAPACITY)) begin
      n_w = NW'(CAPACITY);
    end else begin
      n_w = NW'(size_r);
    end
  end

  assign j_p1   = {1'b0, j_r} + 1'b1;
  assign j_next = (j_p1 == n_w) ? '0 : j_p1[IW-1:0];
  assign cnt_p1 = cnt_r + 1'b1;
  assign cnt_p2 = {1'b0, cnt_p1} + 1'b1;

  assign r_occ   = ram_rdata[WW-1];
  assign r_match = r_occ && (ram_rdata[KEY_W-1:0] == key_r);

  // Shift back when the entry's home is not cyclically inside (gap, cur].
  assign move = ((mod_rem <= gap_r) && (j_r > gap_r)) ||
                ((j_r < mod_rem) && (j_r > gap_r)) ||
                ((j_r < mod_rem) && (mod_rem <= gap_r));

  lph_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (j_r),
    .rdata (ram_rdata)
  );

  lph_mod #(.IW(IW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (n_w),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    st_nxt      = st_r;
    size_nxt    = (cfg_valid) ? cfg_data : size_r;
    clr_nxt     = clr_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    ekey_nxt    = ekey_r;
    home_nxt    = home_r;
    j_nxt       = j_r;
    gap_nxt     = gap_r;
    cnt_nxt     = cnt_r;
    moved_nxt   = moved_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    ov_nxt      = ov_r && !out_ready;
    ost_nxt     = ost_r;
    oval_nxt    = oval_r;
    ram_we      = 1'b0;
    ram_waddr   = gap_r;
    ram_wdata   = '0;
    mod_start   = 1'b0;
    mod_dvd     = key_r;

    case (st_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IW'(CAPACITY - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_kind != K_NONE) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          mod_start = 1'b1;
          mod_dvd   = in_key;
          st_nxt    = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          home_nxt = mod_rem;
          j_nxt    = mod_rem;
          cnt_nxt  = '0;
          st_nxt   = S_PRD;
        end
      end
      S_PRD: begin
        st_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!r_occ) begin
          // empty slot ends the probe
          if (kind_r == K_INSERT) begin
            ram_we      = 1'b1;
            ram_waddr   = j_r;
            ram_wdata   = {1'b1, key_r};
            res_st_nxt  = R_INSERTED;
            res_val_nxt = VALUE_W'(j_r);
          end else begin
            res_st_nxt  = R_NOTFOUND;
            res_val_nxt = '0;
          end
          st_nxt = S_RESP;
        end else if (r_match) begin
          res_val_nxt = VALUE_W'(j_r);
          case (kind_r)
            K_INSERT: begin
              res_st_nxt = R_PRESENT;
              st_nxt     = S_RESP;
            end
            K_FIND: begin
              res_st_nxt = R_FOUND;
              st_nxt     = S_RESP;
            end
            default: begin
              gap_nxt   = j_r;
              j_nxt     = j_next;
              cnt_nxt   = '0;
              moved_nxt = '0;
              st_nxt    = (n_w > NW'(1)) ? S_EREAD : S_EFIN;
            end
          endcase
        end else if (cnt_p1 == n_w) begin
          // every active slot visited, key absent
          j_nxt       = home_r;
          res_st_nxt  = (kind_r == K_INSERT) ? R_FULL : R_NOTFOUND;
          res_val_nxt = '0;
          st_nxt      = S_RESP;
        end else begin
          cnt_nxt = cnt_p1;
          j_nxt   = j_next;
          st_nxt  = S_PRD;
        end
      end
      S_EREAD: begin
        st_nxt = S_ECHK;
      end
      S_ECHK: begin
        if (!r_occ) begin
          st_nxt = S_EFIN;
        end else begin
          ekey_nxt  = ram_rdata[KEY_W-1:0];
          mod_start = 1'b1;
          mod_dvd   = ram_rdata[KEY_W-1:0];
          st_nxt    = S_EHASH;
        end
      end
      S_EHASH: begin
        if (mod_done) begin
          if (move) begin
            ram_we    = 1'b1;
            ram_waddr = gap_r;
            ram_wdata = {1'b1, ekey_r};
            gap_nxt   = j_r;
            moved_nxt = moved_r + 1'b1;
          end
          j_nxt   = j_next;
          cnt_nxt = cnt_p1;
          st_nxt  = (cnt_p2 < {1'b0, n_w}) ? S_EREAD : S_EFIN;
        end
      end
      S_EFIN: begin
        // the final gap is the only slot left to free
        ram_we      = 1'b1;
        ram_waddr   = gap_r;
        ram_wdata   = '0;
        res_st_nxt  = R_ERASED;
        res_val_nxt = moved_r;
        st_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          ost_nxt  = res_st_r;
          oval_nxt = res_val_r;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      size_r <= TABLE_SIZE_RST;
      clr_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      size_r <= size_nxt;
      clr_r  <= clr_nxt;
      ov_r   <= ov_nxt;
    end
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    ekey_r    <= ekey_nxt;
    home_r    <= home_nxt;
    j_r       <= j_nxt;
    gap_r     <= gap_nxt;
    cnt_r     <= cnt_nxt;
    moved_r   <= moved_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    ost_r     <= ost_nxt;
    oval_r    <= oval_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_value  = oval_r;

`ifndef SYNTHESIS
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (st_r == S_HASH || st_r == S_EHASH))
    else $error("remainder result arrived in wrong state");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PCHK) |-> (cnt_r < n_w && {1'b0, j_r} < n_w))
    else $error("probe ran past active size");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && st_r != S_CLR) |-> ({1'b0, ram_waddr} < n_w))
    else $error("slot write outside active size");
`endif

endmodule
